### rtl/dtq_pkg.sv
// Shared types and constants of the deadline timer queue.
// Used by dtq_scan_unit and deadline_timer_queue_top; no dependencies.
`timescale 1ns / 1ps

package dtq_pkg;

  localparam int TIMER_SLOTS_DEF = 32;
  localparam int TIME_BITS_DEF   = 48;

  localparam int SLOT_W   = 5;
  localparam int TMO_W    = 32;
  localparam int NOW_W    = 48;
  localparam int STATUS_W = 3;
  localparam int REM_W    = 48;

  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 64;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_EXPIRE = 2'd2,
    REQ_QUERY  = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_DUPLICATE = 3'd1,
    STS_NOT_ARMED = 3'd2,
    STS_FULL      = 3'd3,
    STS_ZERO_TMO  = 3'd4
  } status_e;

  // Commands from the request sequencer to the slot store.
  typedef struct packed {
    logic arm;       // write deadline and set armed mark
    logic disarm;    // clear armed mark
    logic scan;      // start a search for the earliest deadline
    logic due_only;  // search only among deadlines not after now
  } dtq_cmd_t;

  // Search status from the slot store.
  typedef struct packed {
    logic done;   // search finished this cycle
    logic found;  // an eligible slot was found
  } dtq_scan_sts_t;

endpackage

### rtl/deadline_timer_queue_top.sv
// Top level of the deadline timer queue: request sequencer and result register.
// Depends on dtq_pkg and dtq_scan_unit.
`timescale 1ns / 1ps

// Usage
// Requests arrive as words on the s_axis channel: tuser carries the request
// kind (add, delete, expire, query) and tdata the slot, the timeout and the
// current millisecond time. Results leave as words on the m_axis channel;
// tlast marks the final word caused by a request.
// Add and delete answer one word each. Query answers one word after a
// sweep over the deadline memory. Expire sweeps the memory once per due
// slot, plus one final sweep unless 32 due slots were found, and emits one
// word per due slot, earliest deadline first, at most 32 words, or a single
// word with expired_valid clear when no slot is due. The single read port
// of the deadline memory yields one entry per cycle during a sweep. One
// request is worked on at a time; the next request is accepted once the
// previous one has queued its last word in the output register, even if
// that word is still waiting for the receiver.
// When the receiver stalls, the block holds the pending word and pauses.
// Reset clears all armed marks, so no timer is armed; deadline memory
// contents need no clearing since a deadline is only used while armed.
module deadline_timer_queue_top #(
  parameter int TIMER_SLOTS = dtq_pkg::TIMER_SLOTS_DEF,
  parameter int TIME_BITS   = dtq_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata fields from bit 0 up: slot_id[5], timeout_ms[32], now_ms[48], zero fill[3]
  input  logic [dtq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser fields from bit 0 up: req_type[2]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata fields from bit 0 up: status[3], expired_slot[5], remaining_ms[48],
  // none_armed[1], zero fill[7]
  output logic [dtq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // tuser fields from bit 0 up: expired_valid[1]
  output logic [0:0]                     m_axis_tuser,
  output logic                           m_axis_tlast
);
  import dtq_pkg::*;

  localparam int IDX_W = $clog2(TIMER_SLOTS);
  localparam int SUM_W = TIME_BITS + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESULT,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;

  // Captured request.
  req_e                 req_q, req_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [TMO_W-1:0]     tmo_q, tmo_d;
  logic [TIME_BITS-1:0] now_q, now_d;

  // Expire bookkeeping: one found slot is held back until it is known
  // whether another follows, so that the final word carries tlast.
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [IDX_W-1:0]     pend_slot_q, pend_slot_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic                 out_xv_q, out_xv_d;
  logic [SLOT_W-1:0]    out_slot_q, out_slot_d;
  logic [REM_W-1:0]     out_rem_q, out_rem_d;
  logic                 out_none_q, out_none_d;
  logic                 out_last_q, out_last_d;

  dtq_cmd_t             cmd;
  logic [IDX_W-1:0]     cmd_idx;
  dtq_scan_sts_t        sts;
  logic [TIMER_SLOTS-1:0] armed;
  logic [IDX_W-1:0]     best_idx;
  logic [TIME_BITS-1:0] best_dl;

  logic                 out_free;
  logic [IDX_W-1:0]     slot_idx;
  logic                 slot_ok;
  logic                 slot_armed;
  logic [SUM_W-1:0]     sum;
  logic [TIME_BITS-1:0] add_deadline;
  logic [TIME_BITS-1:0] diff;

  assign out_free   = !out_valid_q || m_axis_tready;
  assign slot_idx   = IDX_W'(slot_q);
  assign slot_ok    = (32'(slot_q) < 32'(TIMER_SLOTS));
  assign slot_armed = slot_ok && armed[slot_idx];

  // Deadline saturates at the top of the time range.
  assign sum          = SUM_W'(now_q) + SUM_W'(tmo_q);
  assign add_deadline = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign diff         = best_dl - now_q;

  assign cmd_idx = (state_q == ST_RESULT) ? best_idx : slot_idx;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    slot_d       = slot_q;
    tmo_d        = tmo_q;
    now_d        = now_q;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_xv_d     = out_xv_q;
    out_slot_d   = out_slot_q;
    out_rem_d    = out_rem_q;
    out_none_d   = out_none_q;
    out_last_d   = out_last_q;
    cmd          = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          req_d        = req_e'(s_axis_tuser);
          slot_d       = s_axis_tdata[SLOT_W-1:0];
          tmo_d        = s_axis_tdata[SLOT_W +: TMO_W];
          now_d        = TIME_BITS'(s_axis_tdata[SLOT_W+TMO_W +: NOW_W]);
          cnt_d        = '0;
          pend_valid_d = 1'b0;
          state_d      = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (req_q)
          REQ_ADD, REQ_DELETE: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_xv_d    = 1'b0;
              out_slot_d  = '0;
              out_rem_d   = '0;
              out_none_d  = 1'b0;
              out_last_d  = 1'b1;
              if (req_q == REQ_ADD) begin
                if (!slot_ok) begin
                  out_status_d = STS_FULL;
                end else if (tmo_q == '0) begin
                  out_status_d = STS_ZERO_TMO;
                end else if (slot_armed) begin
                  out_status_d = STS_DUPLICATE;
                end else begin
                  out_status_d = STS_OK;
                  cmd.arm      = 1'b1;
                end
              end else begin
                if (!slot_armed) begin
                  out_status_d = STS_NOT_ARMED;
                end else begin
                  out_status_d = STS_OK;
                  cmd.disarm   = 1'b1;
                end
              end
              state_d = ST_IDLE;
            end
          end
          default: begin
            cmd.scan     = 1'b1;
            cmd.due_only = (req_q == REQ_EXPIRE);
            state_d      = ST_SCAN;
          end
        endcase
      end

      ST_SCAN: begin
        if (sts.done) begin
          state_d = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (req_q == REQ_QUERY) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = STS_OK;
            out_xv_d     = 1'b0;
            out_slot_d   = '0;
            out_last_d   = 1'b1;
            if (!sts.found) begin
              out_rem_d  = '1;
              out_none_d = 1'b1;
            end else begin
              out_none_d = 1'b0;
              out_rem_d  = (now_q >= best_dl) ? '0 : REM_W'(diff);
            end
            state_d = ST_IDLE;
          end
        end else if (sts.found) begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_valid_d  = 1'b1;
              out_status_d = STS_OK;
              out_xv_d     = 1'b1;
              out_slot_d   = SLOT_W'(pend_slot_q);
              out_rem_d    = '0;
              out_none_d   = 1'b0;
              out_last_d   = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_slot_d  = best_idx;
            cmd.disarm   = 1'b1;
            cnt_d        = cnt_q + RES_CNT_W'(1);
            if (cnt_q == RES_CNT_W'(MAX_RESULTS - 1)) begin
              state_d = ST_FLUSH;
            end else begin
              cmd.scan     = 1'b1;
              cmd.due_only = 1'b1;
              state_d      = ST_SCAN;
            end
          end
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STS_OK;
          out_xv_d     = pend_valid_q;
          out_slot_d   = pend_valid_q ? SLOT_W'(pend_slot_q) : '0;
          out_rem_d    = '0;
          out_none_d   = 1'b0;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STS_OK;
          out_xv_d     = 1'b1;
          out_slot_d   = SLOT_W'(pend_slot_q);
          out_rem_d    = '0;
          out_none_d   = 1'b0;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    slot_q       <= slot_d;
    tmo_q        <= tmo_d;
    now_q        <= now_d;
    pend_slot_q  <= pend_slot_d;
    out_status_q <= out_status_d;
    out_xv_q     <= out_xv_d;
    out_slot_q   <= out_slot_d;
    out_rem_q    <= out_rem_d;
    out_none_q   <= out_none_d;
    out_last_q   <= out_last_d;
  end

  dtq_scan_unit #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .TIME_BITS   (TIME_BITS),
    .IDX_W       (IDX_W)
  ) u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .idx_i           (cmd_idx),
    .wr_deadline_i   (add_deadline),
    .now_i           (now_q),
    .armed_o         (armed),
    .sts_o           (sts),
    .best_idx_o      (best_idx),
    .best_deadline_o (best_dl)
  );

  assign s_axis_tready   = (state_q == ST_IDLE);
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {7'd0, out_none_q, out_rem_q, out_slot_q, out_status_q};
  assign m_axis_tuser[0] = out_xv_q;
  assign m_axis_tlast    = out_last_q;

endmodule

### rtl/dtq_scan_unit.sv
// Slot store of the deadline timer queue: deadline memory, armed marks and
// a sequential earliest-deadline search. Depends on dtq_pkg.
`timescale 1ns / 1ps

module dtq_scan_unit #(
  parameter int TIMER_SLOTS = dtq_pkg::TIMER_SLOTS_DEF,
  parameter int TIME_BITS   = dtq_pkg::TIME_BITS_DEF,
  parameter int IDX_W       = $clog2(TIMER_SLOTS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dtq_pkg::dtq_cmd_t      cmd_i,
  input  logic [IDX_W-1:0]       idx_i,
  input  logic [TIME_BITS-1:0]   wr_deadline_i,
  input  logic [TIME_BITS-1:0]   now_i,
  output logic [TIMER_SLOTS-1:0] armed_o,
  output dtq_pkg::dtq_scan_sts_t sts_o,
  output logic [IDX_W-1:0]       best_idx_o,
  output logic [TIME_BITS-1:0]   best_deadline_o
);
  import dtq_pkg::*;

  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  logic [TIME_BITS-1:0] deadline_mem [TIMER_SLOTS];
  logic [TIME_BITS-1:0] rd_data_q;

  logic [TIMER_SLOTS-1:0] armed_q;
  logic                   scanning_q;
  logic                   due_only_q;
  logic [CNT_W-1:0]       scan_cnt_q;
  logic                   cmp_valid_q;
  logic [IDX_W-1:0]       cmp_idx_q;
  logic                   best_valid_q;
  logic [IDX_W-1:0]       best_idx_q;
  logic [TIME_BITS-1:0]   best_dl_q;

  logic issue;
  logic take;
  logic scan_done;

  assign issue     = scanning_q && (scan_cnt_q < CNT_W'(TIMER_SLOTS));
  assign scan_done = scanning_q && !issue && !cmp_valid_q;

  // A slot replaces the current best only when strictly earlier, so a tie
  // keeps the lower slot found first in the ascending sweep.
  assign take = cmp_valid_q && armed_q[cmp_idx_q]
             && (!due_only_q || (rd_data_q <= now_i))
             && (!best_valid_q || (rd_data_q < best_dl_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.arm) begin
      deadline_mem[idx_i] <= wr_deadline_i;
    end
    if (issue) begin
      rd_data_q <= deadline_mem[scan_cnt_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q      <= '0;
      scanning_q   <= 1'b0;
      due_only_q   <= 1'b0;
      scan_cnt_q   <= '0;
      cmp_valid_q  <= 1'b0;
      cmp_idx_q    <= '0;
      best_valid_q <= 1'b0;
      best_idx_q   <= '0;
    end else begin
      if (cmd_i.arm) begin
        armed_q[idx_i] <= 1'b1;
      end else if (cmd_i.disarm) begin
        armed_q[idx_i] <= 1'b0;
      end
      cmp_valid_q <= issue;
      cmp_idx_q   <= scan_cnt_q[IDX_W-1:0];
      if (cmd_i.scan) begin
        scanning_q   <= 1'b1;
        due_only_q   <= cmd_i.due_only;
        scan_cnt_q   <= '0;
        best_valid_q <= 1'b0;
      end else begin
        if (issue) begin
          scan_cnt_q <= scan_cnt_q + CNT_W'(1);
        end
        if (scan_done) begin
          scanning_q <= 1'b0;
        end
        if (take) begin
          best_valid_q <= 1'b1;
          best_idx_q   <= cmp_idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_dl_q <= rd_data_q;
    end
  end

  assign armed_o         = armed_q;
  assign sts_o.done      = scan_done;
  assign sts_o.found     = best_valid_q;
  assign best_idx_o      = best_idx_q;
  assign best_deadline_o = best_dl_q;

endmodule
